// File: rtl/core/stc_pkg.sv
package stc_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int IdW        = 16;
  localparam int ValW       = 32;

  typedef enum logic {
    OpAdd    = 1'b0,
    OpLookup = 1'b1
  } stc_op_e;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StResp
  } stc_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request payload
    logic search;    // compare, update table, read matched entry
    logic load_out;  // move result into output register
  } stc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or draining this cycle
  } stc_sts_t;

endpackage

// File: rtl/core/stc_if.sv
interface stc_req_if;
  import stc_pkg::*;

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [IdW-1:0]  service_id;
  logic [ValW-1:0] delay_in;
  logic [ValW-1:0] cost_in;

  modport source (output valid, output opcode, output service_id, output delay_in,
                  output cost_in, input ready);
  modport sink   (input valid, input opcode, input service_id, input delay_in,
                  input cost_in, output ready);
endinterface

interface stc_rsp_if;
  import stc_pkg::*;

  logic            valid;
  logic            ready;
  logic            hit;
  logic [ValW-1:0] delay_out;
  logic [ValW-1:0] cost_out;

  modport source (output valid, output hit, output delay_out, output cost_out,
                  input ready);
  modport sink   (input valid, input hit, input delay_out, input cost_out,
                  output ready);
endinterface

// File: rtl/core/service_table_cam.sv
// service_table_cam: small associative table of service entries.
// req_i (sink): opcode add (store id/delay/cost if the id is absent) or
//   lookup (find by id). rsp_o (source): hit, delay_out, cost_out; exactly
//   one response per request, in request order.
// Both channels are valid/ready; a transaction completes on a clock edge
//   with valid and ready high.
// Sequence: request accepted in idle, then a search state (16-way id compare,
//   table update, entry read), then a respond state that loads the output
//   register. The response follows the search registers and the output
//   register; a new request is taken only once the controller is back in
//   idle. The three controller states (idle, search, respond) set this order.
// req_i.ready is high only in idle, so one request is in flight at a time;
//   a finished response may sit in the output register while the next
//   request is taken.
// Receiver stall: the response holds in the output register; the next
//   result waits in the search registers, with the controller held in the
//   respond state, until the register drains.
// Reset (rst_ni, async, active low): table empty, write pointer zero,
//   output empty. Entry storage is not cleared; entries are valid once
//   written. When full, adds of new ids overwrite the oldest entry.
module service_table_cam (
  input  logic         clk_i,
  input  logic         rst_ni,
  stc_req_if.sink      req_i,
  stc_rsp_if.source    rsp_o
);
  import stc_pkg::*;

  stc_cmd_t cmd;
  stc_sts_t sts;

  stc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (req_i.opcode),
    .service_id_i (req_i.service_id),
    .delay_in_i   (req_i.delay_in),
    .cost_in_i    (req_i.cost_in),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .hit_o        (rsp_o.hit),
    .delay_out_o  (rsp_o.delay_out),
    .cost_out_o   (rsp_o.cost_out)
  );

  // one request in flight: controller leaves idle right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one in flight");

  // a miss or an add never carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.hit) |-> (rsp_o.delay_out == '0 && rsp_o.cost_out == '0))
    else $error("nonzero data on response without hit");

  // a response appears only after the controller loads the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.load_out))
    else $error("response valid without load");

  // loading is allowed only when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

endmodule

// File: rtl/core/stc_ctrl.sv
module stc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  stc_pkg::stc_sts_t sts_i,
  output stc_pkg::stc_cmd_t cmd_o
);
  import stc_pkg::*;

  stc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StSearch;
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        state_d      = StResp;
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// File: rtl/core/stc_datapath.sv
module stc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  stc_pkg::stc_cmd_t       cmd_i,
  output stc_pkg::stc_sts_t       sts_o,
  input  logic                    opcode_i,
  input  logic [stc_pkg::IdW-1:0] service_id_i,
  input  logic [stc_pkg::ValW-1:0] delay_in_i,
  input  logic [stc_pkg::ValW-1:0] cost_in_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    hit_o,
  output logic [stc_pkg::ValW-1:0] delay_out_o,
  output logic [stc_pkg::ValW-1:0] cost_out_o
);
  import stc_pkg::*;

  // captured request
  logic            op_q;
  logic [IdW-1:0]  key_q;
  logic [ValW-1:0] dly_q;
  logic [ValW-1:0] cst_q;

  // table state
  logic [IdW-1:0]    id_q [TableDepth];
  logic [2*ValW-1:0] val_mem [TableDepth];
  logic [IdxW-1:0]   wp_q;
  logic [CntW-1:0]   cnt_q;

  // search results
  logic [TableDepth-1:0] hit_vec;
  logic                  hit_any;
  logic [IdxW-1:0]       where;
  logic                  found_q;
  logic [2*ValW-1:0]     rd_q;
  logic                  add_new;

  // output register
  logic            out_valid_q;
  logic            out_hit_q;
  logic [ValW-1:0] out_dly_q;
  logic [ValW-1:0] out_cst_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      key_q <= service_id_i;
      dly_q <= delay_in_i;
      cst_q <= cost_in_i;
    end
  end

  // parallel compare against valid entries, lowest index wins
  always_comb begin
    where = '0;
    for (int i = 0; i < TableDepth; i++) begin
      hit_vec[i] = (CntW'(i) < cnt_q) && (id_q[i] == key_q);
    end
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (hit_vec[i]) where = IdxW'(i);
    end
  end

  assign hit_any = |hit_vec;
  assign add_new = cmd_i.search && (op_q == OpAdd) && !hit_any;

  always_ff @(posedge clk_i) begin
    if (add_new) begin
      id_q[wp_q]    <= key_q;
      val_mem[wp_q] <= {dly_q, cst_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      rd_q    <= val_mem[where];
      found_q <= hit_any;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      cnt_q <= '0;
    end else if (add_new) begin
      wp_q <= (wp_q == IdxW'(TableDepth - 1)) ? '0 : wp_q + 1'b1;
      if (cnt_q < CntW'(TableDepth)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q <= found_q;
      if ((op_q == OpLookup) && found_q) begin
        out_dly_q <= rd_q[2*ValW-1:ValW];
        out_cst_q <= rd_q[ValW-1:0];
      end else begin
        out_dly_q <= '0;
        out_cst_q <= '0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign delay_out_o    = out_dly_q;
  assign cost_out_o     = out_cst_q;

endmodule

// File: dv/service_table_cam_tb.sv
`timescale 1ns / 1ps

module service_table_cam_tb;
  import stc_pkg::*;

  // One request as the sender drives it, one response as the table returns it.
  typedef struct packed {
    stc_op_e         op;
    logic [IdW-1:0]  id;
    logic [ValW-1:0] dly;
    logic [ValW-1:0] cst;
  } svc_req_t;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] dly;
    logic [ValW-1:0] cst;
  } svc_rsp_t;

  // Directed row: request plus, where it is obvious, the response typed in.
  typedef struct {
    svc_req_t req;
    bit       typed;
    svc_rsp_t want;
  } svc_row_t;

  localparam int RandomItems   = 1500;
  localparam int IdPoolSize    = 24;   // more than the depth, so FIFO eviction happens
  localparam int PressureItem  = 700;  // random item before which the sender drains
  localparam int WatchdogLimit = 1000; // cycles without any transaction
  localparam int MaxReported   = 10;

  logic clk_i;
  logic rst_ni;

  stc_req_if svc_req_if ();
  stc_rsp_if svc_rsp_if ();

  service_table_cam uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (svc_req_if),
    .rsp_o  (svc_rsp_if)
  );

  // Shadow of the table: ids, delays, costs, ring pointer, valid count.
  logic [IdW-1:0]  tbl_id  [TableDepth];
  logic [ValW-1:0] tbl_dly [TableDepth];
  logic [ValW-1:0] tbl_cst [TableDepth];
  int              tbl_wptr;
  int              tbl_count;

  // Responses owed by the table, oldest first.
  svc_rsp_t svc_due_q[$];
  svc_row_t dir_rows[$];

  int err_cnt;
  int idle_cycles;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Apply one request to the shadow table and return the response it owes.
  // Lowest valid index wins a match; only entries below the count are live.
  function automatic svc_rsp_t svc_table_apply(svc_req_t r);
    svc_rsp_t res;
    int       slot;
    res  = '0;
    slot = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (slot < 0 && tbl_id[i] == r.id) slot = i;
    end
    res.hit = (slot >= 0);
    if (r.op == OpAdd) begin
      // add of a present id is dropped; otherwise write at the ring pointer,
      // which overwrites the oldest entry once the table is full
      if (slot < 0) begin
        tbl_id[tbl_wptr]  = r.id;
        tbl_dly[tbl_wptr] = r.dly;
        tbl_cst[tbl_wptr] = r.cst;
        if (tbl_count < TableDepth) tbl_count++;
        tbl_wptr = (tbl_wptr == TableDepth - 1) ? 0 : tbl_wptr + 1;
      end
    end else if (slot >= 0) begin
      res.dly = tbl_dly[slot];
      res.cst = tbl_cst[slot];
    end
    return res;
  endfunction

  // Append one directed row.
  function automatic void dir_add(svc_req_t req, bit typed, svc_rsp_t want);
    svc_row_t row;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    dir_rows  = {dir_rows, row};
  endfunction

  // Drive one request after a random gap and wait for its transaction.
  // valid stays high across back-to-back requests (no drop/raise in one step).
  bit req_calm;

  task automatic svc_send(svc_req_t r, bit typed, svc_rsp_t want);
    int       gap;
    svc_rsp_t due;
    if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
    gap = req_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      svc_req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    svc_req_if.valid      <= 1'b1;
    svc_req_if.opcode     <= r.op;
    svc_req_if.service_id <= r.id;
    svc_req_if.delay_in   <= r.dly;
    svc_req_if.cost_in    <= r.cst;
    @(posedge clk_i);
    while (!svc_req_if.ready) @(posedge clk_i);
    // accepted at this edge: shadow state always advances, the typed
    // response (if any) replaces the predicted one
    due = svc_table_apply(r);
    if (typed) due = want;
    svc_due_q = {svc_due_q, due};
  endtask

  // Response side: random stalls on ready, check each transaction in order.
  bit rsp_calm;

  initial begin
    int       stall;
    svc_rsp_t want;
    svc_rsp_t got;
    forever begin
      if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
      stall = rsp_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        svc_rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      svc_rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(svc_rsp_if.valid && rst_ni)) @(posedge clk_i);
      got = '{svc_rsp_if.hit, svc_rsp_if.delay_out, svc_rsp_if.cost_out};
      if (svc_due_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReported)
          $display("[%0t] response with nothing outstanding: hit=%0b delay=%h cost=%h",
                   $realtime, got.hit, got.dly, got.cst);
      end else begin
        want = svc_due_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MaxReported)
            $display("[%0t] mismatch: exp hit=%0b delay=%h cost=%h, got hit=%0b delay=%h cost=%h",
                     $realtime, want.hit, want.dly, want.cst, got.hit, got.dly, got.cst);
        end
      end
    end
  end

  // Watchdog: any cycle after reset with no transaction on either side counts.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (svc_req_if.valid && svc_req_if.ready) ||
          (svc_rsp_if.valid && svc_rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [IdW-1:0] id_pool [IdPoolSize];
    svc_req_t       r;
    logic [IdW-1:0] k;

    err_cnt   = 0;
    tbl_wptr  = 0;
    tbl_count = 0;
    req_calm  = 1'b0;
    rsp_calm  = 1'b0;

    rst_ni                <= 1'b0;
    svc_req_if.valid      <= 1'b0;
    svc_req_if.opcode     <= OpAdd;
    svc_req_if.service_id <= '0;
    svc_req_if.delay_in   <= '0;
    svc_req_if.cost_in    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Empty-table lookups miss; add results are always zero
    // payload; extremes of id, delay and cost round-trip unchanged.
    dir_add(svc_req_t'{OpLookup, 16'h0000, 32'h0, 32'h0}, 1'b1,
            svc_rsp_t'{1'b0, 32'h0, 32'h0});
    dir_add(svc_req_t'{OpLookup, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
            svc_rsp_t'{1'b0, 32'h0, 32'h0});
    dir_add(svc_req_t'{OpAdd, 16'h0000, 32'hFFFF_FFFF, 32'h0}, 1'b1,
            svc_rsp_t'{1'b0, 32'h0, 32'h0});
    // duplicate add: dropped, hit reported, stored values untouched
    dir_add(svc_req_t'{OpAdd, 16'h0000, 32'h0000_0001, 32'h0000_0001}, 1'b1,
            svc_rsp_t'{1'b1, 32'h0, 32'h0});
    dir_add(svc_req_t'{OpLookup, 16'h0000, 32'h0, 32'h0}, 1'b1,
            svc_rsp_t'{1'b1, 32'hFFFF_FFFF, 32'h0});
    dir_add(svc_req_t'{OpAdd, 16'hFFFF, 32'h0, 32'hFFFF_FFFF}, 1'b1,
            svc_rsp_t'{1'b0, 32'h0, 32'h0});
    dir_add(svc_req_t'{OpLookup, 16'hFFFF, 32'h0, 32'h0}, 1'b1,
            svc_rsp_t'{1'b1, 32'h0, 32'hFFFF_FFFF});
    // fill to the depth, count saturates
    for (int i = 1; i <= TableDepth - 2; i++) begin
      k = IdW'(i);
      dir_add(svc_req_t'{OpAdd, k, {k, 16'h8000}, ~{k, 16'h8000}}, 1'b0, svc_rsp_t'(0));
    end
    // table full: new id evicts the oldest (id 0), others stay
    dir_add(svc_req_t'{OpAdd, 16'h5555, 32'hA5A5_5A5A, 32'h0F0F_F0F0}, 1'b0, svc_rsp_t'(0));
    dir_add(svc_req_t'{OpLookup, 16'h0000, 32'h0, 32'h0}, 1'b0, svc_rsp_t'(0));
    dir_add(svc_req_t'{OpLookup, 16'h5555, 32'h0, 32'h0}, 1'b0, svc_rsp_t'(0));
    dir_add(svc_req_t'{OpLookup, 16'hFFFF, 32'h0, 32'h0}, 1'b0, svc_rsp_t'(0));

    foreach (dir_rows[i]) svc_send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Random part: ids mostly from a pool a bit larger than the table, so
    // duplicate adds, hits and FIFO eviction are all frequent.
    foreach (id_pool[i]) id_pool[i] = IdW'($urandom_range(0, 65535));
    for (int n = 0; n < RandomItems; n++) begin
      if (n == PressureItem) begin
        // drop valid and let every owed response drain before going on
        svc_req_if.valid <= 1'b0;
        while (svc_due_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 199) == 0)
        id_pool[$urandom_range(0, IdPoolSize - 1)] = IdW'($urandom_range(0, 65535));
      r.op  = stc_op_e'($urandom_range(0, 1));
      r.id  = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, IdPoolSize - 1)]
                                            : IdW'($urandom_range(0, 65535));
      r.dly = $urandom;
      r.cst = $urandom;
      svc_send(r, 1'b0, svc_rsp_t'(0));
    end
    svc_req_if.valid <= 1'b0;

    // drain, then wait for anything stray; the watchdog bounds this
    while (svc_due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0 && svc_due_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
